[rtl/cle_pkg.sv]
// Shared definitions for the console line editor: kind codes, character codes,
// byte classes, echo tables and the controller/datapath command and status types.
// No dependencies.
package cle_pkg;

    localparam int LINE_MAX_DEF = 32;
    localparam int LEN_W        = 6;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 6'd32;

    // result kinds
    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // character codes
    localparam logic [7:0] CH_EOT   = 8'h04;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // byte classes, decided when the byte is taken
    localparam logic [2:0] CLS_EOT   = 3'd0;
    localparam logic [2:0] CLS_CR    = 3'd1;
    localparam logic [2:0] CLS_LF    = 3'd2;
    localparam logic [2:0] CLS_BSDEL = 3'd3;
    localparam logic [2:0] CLS_BSNOP = 3'd4;
    localparam logic [2:0] CLS_OTHER = 3'd5;

    typedef struct packed {
        logic       take;
        logic       echo_load;
        logic [1:0] echo_step;
        logic       echo_last;
        logic       line_load;
        logic       mark_load;
    } cle_cmd_t;

    typedef struct packed {
        logic [2:0] cls;
        logic       done;
        logic       idx_end;
        logic       out_free;
    } cle_sts_t;

    // number of echo beats for a byte class
    function automatic logic [1:0] echo_len(input logic [2:0] cls);
        logic [1:0] n;
        case (cls)
            CLS_CR:    n = 2'd2;
            CLS_LF:    n = 2'd1;
            CLS_BSDEL: n = 2'd3;
            CLS_OTHER: n = 2'd1;
            default:   n = 2'd0;
        endcase
        return n;
    endfunction

    // echo character for a given beat of a byte class
    function automatic logic [7:0] echo_char(input logic [2:0] cls,
                                             input logic [1:0] step,
                                             input logic [7:0] rx);
        logic [7:0] ch;
        case (cls)
            CLS_CR:    ch = (step == 2'd0) ? CH_CR : CH_LF;
            CLS_LF:    ch = CH_LF;
            CLS_BSDEL: ch = (step == 2'd1) ? CH_SPACE : CH_BS;
            CLS_OTHER: ch = rx;
            default:   ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[rtl/cle_datapath.sv]
// Datapath of the console line editor: line store, counts, limit register,
// byte decode and the output register.
// Depends on cle_pkg.
module cle_datapath
    import cle_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [LEN_W-1:0] cfg_data,
    input  logic [7:0]       rx_byte,
    input  logic             out_stall,
    input  cle_cmd_t         cmd,
    output cle_sts_t         sts,
    output logic             out_valid,
    output logic [1:0]       out_kind,
    output logic [7:0]       out_byte,
    output logic [LEN_W-1:0] line_length,
    output logic             last
);

    localparam int CW   = $clog2(LINE_MAX + 1);
    localparam int AW   = $clog2(LINE_MAX);
    localparam int CMPW = ((CW > LEN_W) ? CW : LEN_W) + 1;

    logic [LEN_W-1:0] max_len_reg, max_len_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    seen_reg, seen_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [2:0]       cls_reg, cls_next;
    logic             done_reg, done_next;
    logic [7:0]       byte_reg;
    logic [7:0]       rd_data_reg;
    logic [7:0]       mem [LINE_MAX];

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_kind_reg, out_kind_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic [LEN_W-1:0] out_len_reg, out_len_next;
    logic             out_last_reg, out_last_next;

    logic             store_en;
    logic [7:0]       store_data;
    logic [CW-1:0]    seen_inc;
    logic [CMPW-1:0]  max_ext;
    logic [CMPW-1:0]  limit;
    logic             room;
    logic [AW-1:0]    rd_addr;

    assign max_len_next = cfg_write_en ? cfg_data : max_len_reg;

    // clamp the limit to 1..LINE_MAX
    always_comb
    begin
        max_ext = CMPW'(max_len_reg);
        if (max_len_reg == '0)
            limit = CMPW'(1);
        else if (max_ext > CMPW'(LINE_MAX))
            limit = CMPW'(LINE_MAX);
        else
            limit = max_ext;
    end

    assign room     = count_reg < CW'(LINE_MAX);
    assign seen_inc = seen_reg + CW'(1);

    // decode the byte being taken and update the counts
    always_comb
    begin
        cls_next   = cls_reg;
        done_next  = done_reg;
        count_next = count_reg;
        seen_next  = seen_reg;
        store_en   = 1'b0;
        store_data = rx_byte;
        if (cmd.take)
        begin
            case (rx_byte)
                CH_EOT:
                begin
                    cls_next  = CLS_EOT;
                    done_next = 1'b1;
                end
                CH_CR, CH_LF:
                begin
                    cls_next   = (rx_byte == CH_CR) ? CLS_CR : CLS_LF;
                    done_next  = 1'b1;
                    store_data = CH_LF;
                    store_en   = room;
                    if (room)
                        count_next = count_reg + CW'(1);
                end
                CH_BS:
                begin
                    if (count_reg != '0)
                    begin
                        cls_next   = CLS_BSDEL;
                        count_next = count_reg - CW'(1);
                    end
                    else
                        cls_next = CLS_BSNOP;
                    seen_next = seen_inc;
                    done_next = CMPW'(seen_inc) >= limit;
                end
                default:
                begin
                    cls_next  = CLS_OTHER;
                    store_en  = room;
                    if (room)
                        count_next = count_reg + CW'(1);
                    seen_next = seen_inc;
                    done_next = CMPW'(seen_inc) >= limit;
                end
            endcase
        end
        else if (cmd.mark_load)
        begin
            count_next = '0;
            seen_next  = '0;
        end
    end

    // read pointer for the dump: restart on take, advance per line beat
    always_comb
    begin
        if (cmd.take)
            idx_next = '0;
        else if (cmd.line_load)
            idx_next = idx_reg + CW'(1);
        else
            idx_next = idx_reg;
    end

    assign rd_addr = idx_next[AW-1:0];

    // output register
    always_comb
    begin
        out_kind_next = out_kind_reg;
        out_byte_next = out_byte_reg;
        out_len_next  = out_len_reg;
        out_last_next = out_last_reg;
        if (cmd.echo_load)
        begin
            out_kind_next = KIND_ECHO;
            out_byte_next = echo_char(cls_reg, cmd.echo_step, byte_reg);
            out_len_next  = '0;
            out_last_next = cmd.echo_last;
        end
        else if (cmd.line_load)
        begin
            out_kind_next = KIND_LINE;
            out_byte_next = rd_data_reg;
            out_len_next  = '0;
            out_last_next = 1'b0;
        end
        else if (cmd.mark_load)
        begin
            out_kind_next = KIND_END;
            out_byte_next = 8'h00;
            out_len_next  = LEN_W'(count_reg);
            out_last_next = 1'b1;
        end

        if (cmd.echo_load || cmd.line_load || cmd.mark_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_LEN_RESET;
            count_reg     <= '0;
            seen_reg      <= '0;
            idx_reg       <= '0;
            cls_reg       <= CLS_EOT;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            max_len_reg   <= max_len_next;
            count_reg     <= count_next;
            seen_reg      <= seen_next;
            idx_reg       <= idx_next;
            cls_reg       <= cls_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            byte_reg <= rx_byte;
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

    // line store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (store_en)
            mem[count_reg[AW-1:0]] <= store_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign sts.cls      = cls_reg;
    assign sts.done     = done_reg;
    assign sts.idx_end  = idx_reg == count_reg;
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_byte    = out_byte_reg;
    assign line_length = out_len_reg;
    assign last        = out_last_reg;

endmodule

[rtl/cle_controller.sv]
// Controller of the console line editor: sequences the take, echo, line dump
// and end marker of each received byte.
// Depends on cle_pkg.
module cle_controller
    import cle_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  cle_sts_t sts,
    output cle_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ECHO = 2'd1;
    localparam logic [1:0] S_LINE = 2'd2;
    localparam logic [1:0] S_MARK = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic [1:0] n_echo;

    assign n_echo = echo_len(sts.cls);

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        cmd           = '0;
        cmd.echo_step = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    step_next  = 2'd0;
                    state_next = S_ECHO;
                end
            end
            S_ECHO:
            begin
                if (step_reg == n_echo)
                    state_next = sts.done ? S_LINE : S_IDLE;
                else if (sts.out_free)
                begin
                    cmd.echo_load = 1'b1;
                    cmd.echo_last = (step_reg == n_echo - 2'd1) && !sts.done;
                    step_next     = step_reg + 2'd1;
                end
            end
            S_LINE:
            begin
                if (sts.idx_end)
                    state_next = S_MARK;
                else if (sts.out_free)
                    cmd.line_load = 1'b1;
            end
            S_MARK:
            begin
                if (sts.out_free)
                begin
                    cmd.mark_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign in_stall = state_reg != S_IDLE;

endmodule

[rtl/console_line_editor_top.sv]
// Console line editor: turns received console bytes into echo beats and
// finished lines. Takes cle_controller, cle_datapath and cle_pkg.
//
// One received byte is taken at a time; in_stall stays high until every beat
// it causes has been loaded into the output register. Each byte gives its echo
// beats (none, one, two or three), and when it ends the line, one beat per
// stored byte followed by an end marker carrying the length. The single output
// register sets the pace at one beat per cycle while out_stall is low. The line
// store has one write and one registered read port; its contents are undefined
// after reset and only written entries are ever read out. max_len is taken by
// cfg_write_en/cfg_data and should be written only while the block is idle; a
// value of zero acts as one, values above LINE_MAX act as LINE_MAX.
module console_line_editor_top
    import cle_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration: max_len
    input  logic             cfg_write_en,
    input  logic [LEN_W-1:0] cfg_data,
    // receive side
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       rx_byte,
    // result side
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       out_kind,
    output logic [7:0]       out_byte,
    output logic [LEN_W-1:0] line_length,
    output logic             last
);

    cle_cmd_t cmd;
    cle_sts_t sts;

    // sequence take, echo, dump and marker
    cle_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // hold the line, counts and the outgoing beat
    cle_datapath #(
        .LINE_MAX (LINE_MAX)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_data     (cfg_data),
        .rx_byte      (rx_byte),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_kind     (out_kind),
        .out_byte     (out_byte),
        .line_length  (line_length),
        .last         (last)
    );

endmodule

[sim/console_line_editor_top_test.sv]
// Self-checking testbench for console_line_editor_top: echo, backspace, line end and limit.
// Predicts every output beat from its own line model and checks each accepted beat in order.
// Depends on rtl/cle_pkg.sv and rtl/console_line_editor_top.sv.
`timescale 1ns / 1ps

module console_line_editor_top_test;
    import cle_pkg::*;

    // One expected output beat, at the widths of the result ports.
    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
        logic             last;
    } out_beat_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             cfg_write_en = 1'b0;
    logic [LEN_W-1:0] cfg_data     = '0;
    logic             in_valid     = 1'b0;
    logic             in_stall;
    logic [7:0]       rx_byte      = '0;
    logic             out_valid;
    logic             out_stall    = 1'b0;
    logic [1:0]       out_kind;
    logic [7:0]       out_byte;
    logic [LEN_W-1:0] line_length;
    logic             last;

    // Shadow of the editor: line contents, stored count, received count, limit register.
    logic [7:0]       shadow_line [LINE_MAX_DEF];
    int               shadow_count;
    int               shadow_seen;
    logic [LEN_W-1:0] shadow_max_len;

    // Beats caused by the byte being predicted, then the queue of beats still owed.
    out_beat_t        step_beats [LINE_MAX_DEF+3];
    int               step_n;
    out_beat_t        pending_beats [$];

    int               mismatch_count = 0;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;

    console_line_editor_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_kind     (out_kind),
        .out_byte     (out_byte),
        .line_length  (line_length),
        .last         (last)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------------
    // Line model
    // ---------------------------------------------------------------------

    function automatic void add_beat(input logic [1:0] k, input logic [7:0] d,
                                     input logic [LEN_W-1:0] l);
        step_beats[step_n] = '{kind: k, data: d, len: l, last: 1'b0};
        step_n++;
    endfunction

    // Append to the line; a full store silently drops the byte.
    function automatic void keep_char(input logic [7:0] c);
        if (shadow_count < LINE_MAX_DEF)
        begin
            shadow_line[shadow_count] = c;
            shadow_count++;
        end
    endfunction

    // Work out every beat one received byte causes and queue them, marking the
    // final one with last.
    function automatic void predict_editor_beats(input logic [7:0] rx);
        int  lim;
        bit  ends;
        int  i;
        step_n = 0;
        ends   = 1'b0;
        // clamp the limit into 1..LINE_MAX; zero behaves as one
        lim = int'(shadow_max_len);
        if (lim < 1)
            lim = 1;
        if (lim > LINE_MAX_DEF)
            lim = LINE_MAX_DEF;

        if (rx == CH_EOT)
            ends = 1'b1;
        else if (rx == CH_CR)
        begin
            keep_char(CH_LF);
            add_beat(KIND_ECHO, CH_CR, '0);
            add_beat(KIND_ECHO, CH_LF, '0);
            ends = 1'b1;
        end
        else if (rx == CH_LF)
        begin
            keep_char(CH_LF);
            add_beat(KIND_ECHO, CH_LF, '0);
            ends = 1'b1;
        end
        else
        begin
            if (rx == CH_BS)
            begin
                // rub out the last character; an empty line gives no echo
                if (shadow_count > 0)
                begin
                    shadow_count--;
                    add_beat(KIND_ECHO, CH_BS, '0);
                    add_beat(KIND_ECHO, CH_SPACE, '0);
                    add_beat(KIND_ECHO, CH_BS, '0);
                end
            end
            else
            begin
                keep_char(rx);
                add_beat(KIND_ECHO, rx, '0);
            end
            // backspaces count towards the limit too
            shadow_seen++;
            if (shadow_seen >= lim)
                ends = 1'b1;
        end

        if (ends)
        begin
            for (i = 0; i < shadow_count; i++)
                add_beat(KIND_LINE, shadow_line[i], '0);
            add_beat(KIND_END, 8'h00, LEN_W'(shadow_count));
            shadow_count = 0;
            shadow_seen  = 0;
        end

        for (i = 0; i < step_n; i++)
        begin
            step_beats[i].last = (i == step_n - 1);
            pending_beats.push_back(step_beats[i]);
        end
    endfunction

    // ---------------------------------------------------------------------
    // Result side: check each accepted beat, then pick the next stall at random
    // ---------------------------------------------------------------------

    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_beats.size() == 0)
            begin
                $error("unexpected beat: kind %0d byte 0x%02h length %0d last %0d",
                       out_kind, out_byte, line_length, last);
                mismatch_count++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (out_kind !== want.kind)
                begin
                    $error("out_kind: expected %0d, actual %0d", want.kind, out_kind);
                    mismatch_count++;
                end
                if (out_byte !== want.data)
                begin
                    $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, out_byte);
                    mismatch_count++;
                end
                if (line_length !== want.len)
                begin
                    $error("line_length: expected %0d, actual %0d", want.len, line_length);
                    mismatch_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    mismatch_count++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ---------------------------------------------------------------------
    // Shared stimulus tasks
    // ---------------------------------------------------------------------

    // Offer one byte, idling first at random, and hold it until in_stall is low again.
    // Valid stays high on return so back-to-back bytes need no second assignment.
    task automatic send_rx(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        predict_editor_beats(b);
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid and wait until every owed beat has come out. A byte with no
    // result may still be in flight, so allow a short settling pause after.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Write max_len; only called with the editor idle.
    task automatic write_max_len(input logic [LEN_W-1:0] v);
        cfg_write_en <= 1'b1;
        cfg_data     <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        shadow_max_len = v;
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Plain bytes at the extremes of the field echo as themselves; CR ends the line.
    task automatic test_plain_echo();
        send_rx(8'h00);
        send_rx(8'hFF);
        send_rx(8'h55);
        send_rx(8'hAA);
        send_rx(CH_CR);
    endtask

    // Backspace on an empty line, rubbing out characters, then an LF line end.
    task automatic test_backspace();
        send_rx(CH_BS);
        send_rx(8'h61);
        send_rx(8'h62);
        send_rx(CH_BS);
        send_rx(CH_BS);
        send_rx(CH_BS);
        send_rx(CH_LF);
    endtask

    // EOT on an empty line gives only the marker; after a character it ends the line.
    task automatic test_eot();
        send_rx(CH_EOT);
        send_rx(8'h78);
        send_rx(CH_EOT);
    endtask

    // Limit of one, zero (acts as one) and above the store size (acts as full size).
    // Hold off each register write until the editor has gone quiet.
    task automatic test_limit_edges();
        drain_results();
        write_max_len(LEN_W'(1));
        send_rx(8'h71);
        // empty-line backspace reaching the limit: marker alone, length zero
        send_rx(CH_BS);
        drain_results();
        write_max_len(LEN_W'(0));
        send_rx(8'hFF);
        drain_results();
        write_max_len(LEN_W'(63));
        send_rx(8'h7A);
        send_rx(CH_CR);
    endtask

    // One traffic phase: settle, set the limit and idling, send one full-length
    // line, then mostly well-formed editing with some noise on top.
    task automatic test_traffic(input int n_items, input int idle_pct, input int stall_pct,
                                input logic [LEN_W-1:0] len_setting);
        int sent;
        int lim;
        int i;
        int pick;
        logic [7:0] b;
        drain_results();
        write_max_len(len_setting);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        lim = int'(len_setting);
        if (lim < 1)
            lim = 1;
        if (lim > LINE_MAX_DEF)
            lim = LINE_MAX_DEF;

        // clear whatever is left of the line, then fill it to one short of the
        // limit and end with CR: with the full limit this is the longest burst
        send_rx(CH_EOT);
        for (i = 0; i < lim - 1; i++)
            send_rx(8'($urandom_range(8'h21, 8'h7E)));
        send_rx(CH_CR);
        sent = lim + 1;

        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                b = 8'($urandom_range(8'h20, 8'h7E));
            else if (pick < 70)
                b = 8'($urandom_range(255));
            else if (pick < 82)
                b = CH_BS;
            else if (pick < 90)
                b = CH_CR;
            else if (pick < 95)
                b = CH_LF;
            else
                b = CH_EOT;
            send_rx(b);
            sent++;
        end
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------

    initial
    begin
        shadow_count   = 0;
        shadow_seen    = 0;
        shadow_max_len = MAX_LEN_RESET;

        // hold reset low at the start, release it once, never again
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_plain_echo();
        test_backspace();
        test_eot();
        test_limit_edges();

        // phases: no idling, sender idle, receiver stalling, both
        test_traffic(78, 0, 0, LEN_W'(32));
        test_traffic(78, 60, 0, LEN_W'(5));
        test_traffic(78, 0, 60, LEN_W'(20));
        test_traffic(78, 19, 19, LEN_W'(63));

        drain_results();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && pending_beats.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/cle_pkg.sv
rtl/cle_datapath.sv
rtl/cle_controller.sv
rtl/console_line_editor_top.sv
sim/console_line_editor_top_test.sv
